// ===== sv/elwt_pkg.sv =====
// Package for the event watch table: field widths, action and status codes,
// readiness bit masks and the packed slot and result records.
// No dependencies; every other file of the block but elwt_ram uses it.
package elwt_pkg;

	localparam int ACTION_W = 3;
	localparam int FD_W     = 8;
	localparam int BITS_W   = 5;
	localparam int TAG_W    = 64;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [FD_W-1:0]     fd_t;
	typedef logic [BITS_W-1:0]   bits_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam action_t ACT_ADD    = 3'd0;
	localparam action_t ACT_MODIFY = 3'd1;
	localparam action_t ACT_REMOVE = 3'd2;
	localparam action_t ACT_SETRDY = 3'd3;
	localparam action_t ACT_SCAN   = 3'd4;
	localparam action_t ACT_PROBE  = 3'd5;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_ALREADY     = 2'd1;
	localparam status_t ST_NOT_WATCHED = 2'd2;
	localparam status_t ST_FULL        = 2'd3;

	localparam bits_t BIT_IN  = 5'h01;
	localparam bits_t BIT_OUT = 5'h04;
	localparam bits_t BIT_ERR = 5'h08;
	localparam bits_t BIT_HUP = 5'h10;

	localparam count_t MAX_EVENTS_RST = 7'd64;

	// One watch slot as it sits in the slot memory.
	typedef struct packed {
		logic  used;
		fd_t   desc;
		bits_t interest;
		logic  edge_trig;
		bits_t seen;
		tag_t  tag;
	} slot_word_t;

	// One result item.
	typedef struct packed {
		status_t status;
		logic    is_event;
		bits_t   report_bits;
		tag_t    user_tag;
		count_t  event_count;
		logic    any_ready;
		logic    last;
	} res_t;

endpackage

// ===== sv/elwt_ifs.sv =====
// Valid/ready channel interfaces of the event watch table: the command
// channel and the result channel. Depends on elwt_pkg for field types.
interface elwt_cmd_if;
	logic              valid;
	logic              ready;
	elwt_pkg::action_t action;
	elwt_pkg::fd_t     fd;
	elwt_pkg::bits_t   event_mask;
	logic              edge_mode;
	elwt_pkg::tag_t    cookie;
	elwt_pkg::bits_t   ready_bits;

	modport source (output valid, action, fd, event_mask, edge_mode, cookie, ready_bits,
		input ready);
	modport sink (input valid, action, fd, event_mask, edge_mode, cookie, ready_bits,
		output ready);
endinterface

interface elwt_rsp_if;
	logic              valid;
	logic              ready;
	elwt_pkg::status_t status;
	logic              is_event;
	elwt_pkg::bits_t   report_bits;
	elwt_pkg::tag_t    user_tag;
	elwt_pkg::count_t  event_count;
	logic              any_ready;
	logic              last;

	modport source (output valid, status, is_event, report_bits, user_tag, event_count,
		any_ready, last, input ready);
	modport sink (input valid, status, is_event, report_bits, user_tag, event_count,
		any_ready, last, output ready);
endinterface

// ===== sv/edge_level_event_watch_table.sv =====
// Top level of the event watch table: sequencer, slot walk pipeline and
// result register. Depends on elwt_pkg, elwt_ifs (elwt_cmd_if, elwt_rsp_if)
// and elwt_ram.
//
//  Channel | Direction | Handshake     | Carries
//  --------+-----------+---------------+------------------------------------------
//  cmd     | in        | valid / ready | action, fd, event_mask, edge_mode, ...
//  rsp     | out       | valid / ready | status, is_event, report_bits, ..., last
//  cfg     | in        | cfg_we only   | max_events (7 bits)
//
// Add, modify, remove, scan and probe walk the slot memory in index order, one
// slot per cycle while the result channel does not stall; each slot word read
// from the single read port of the slot memory then addresses the readiness
// memory for that slot's descriptor.
// Modify, remove, probe and an add of a watched descriptor stop at the first hit.
// Set readiness, unknown actions and zero-limit scans skip the walk to the final result.
// After reset a clearing pass zeroes every address of both memories; cmd.ready
// stays low during it.
// A stalled result channel freezes the walk; the next command is taken while the
// final result of the previous one still waits in the output register.
module edge_level_event_watch_table #(
	parameter int WATCH_SLOTS      = 256,
	parameter int DESCRIPTOR_COUNT = 256,
	parameter int MAX_REPORT       = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  elwt_pkg::count_t  cfg_data,
	elwt_cmd_if.sink          cmd,
	elwt_rsp_if.source        rsp
);

	localparam int SA    = $clog2(WATCH_SLOTS);
	localparam int DA    = $clog2(DESCRIPTOR_COUNT);
	localparam int IW    = SA + 1;
	localparam int CLR_N = (WATCH_SLOTS > DESCRIPTOR_COUNT) ? WATCH_SLOTS : DESCRIPTOR_COUNT;
	localparam int CW    = $clog2(CLR_N);
	localparam int SW    = $bits(elwt_pkg::slot_word_t);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	// Control state
	logic [1:0]       state_q;
	logic [CW-1:0]    clr_q;
	logic [IW-1:0]    issue_q;
	logic             vld_s1, vld_s2;
	elwt_pkg::count_t max_events_q;
	elwt_pkg::count_t cnt_q;
	elwt_pkg::count_t lim_q;
	logic             dup_q, free_vld_q, found_q, any_q, pend_vld_q, out_vld_q;

	// Payload registers of the command in flight
	elwt_pkg::action_t act_q;
	elwt_pkg::fd_t     fd_q;
	elwt_pkg::bits_t   mask_q;
	logic              edge_q;
	elwt_pkg::tag_t    tag_q;

	// Walk pipeline payload
	logic [SA-1:0]        idx_s1, idx_s2;
	elwt_pkg::slot_word_t slot_s2;
	logic                 rng_s2;
	logic [SA-1:0]        free_idx_q;

	// Pending scan event: held back until we know whether it is the last one.
	elwt_pkg::bits_t  pend_bits_q;
	elwt_pkg::tag_t   pend_tag_q;
	elwt_pkg::count_t pend_cnt_q;

	elwt_pkg::res_t res_q;

	// Memory ports
	logic                 slot_we, slot_re;
	logic [SA-1:0]        slot_waddr;
	elwt_pkg::slot_word_t slot_wdata, slot_rd;
	logic [SW-1:0]        slot_rd_raw;
	logic                 rdy_we, rdy_re;
	logic [DA-1:0]        rdy_waddr, rdy_raddr;
	elwt_pkg::bits_t      rdy_wdata, rdy_rd;

	// Combinational control
	logic             accept, adv, walk_go, hit, issue_done, walk_end, stop;
	logic             match_s2, ev_hit, out_load, cmd_rng;
	elwt_pkg::bits_t  rdy_eff, wanted, rep;
	elwt_pkg::count_t limit, cnt_nxt;
	elwt_pkg::res_t   out_data, fin_res;

	elwt_ram #(.DEPTH(WATCH_SLOTS), .WIDTH(SW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (issue_q[SA-1:0]),
		.rdata (slot_rd_raw)
	);

	elwt_ram #(.DEPTH(DESCRIPTOR_COUNT), .WIDTH(elwt_pkg::BITS_W)) u_rdy_ram (
		.clk   (clk),
		.we    (rdy_we),
		.waddr (rdy_waddr),
		.wdata (rdy_wdata),
		.re    (rdy_re),
		.raddr (rdy_raddr),
		.rdata (rdy_rd)
	);

	assign slot_rd = elwt_pkg::slot_word_t'(slot_rd_raw);

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// The output register can take a new result when empty or being drained.
	assign adv     = !out_vld_q || rsp.ready;
	assign walk_go = (state_q == ST_WALK) && adv;
	assign hit     = walk_go && vld_s2;

	assign issue_done = (issue_q >= IW'(WATCH_SLOTS));
	assign walk_end   = walk_go && issue_done && !vld_s1 && !vld_s2;

	// The readiness memory is addressed straight from the slot word just read.
	assign slot_re   = walk_go;
	assign rdy_re    = walk_go;
	assign rdy_raddr = DA'(slot_rd.desc);

	assign limit   = (max_events_q < elwt_pkg::count_t'(MAX_REPORT)) ? max_events_q
		: elwt_pkg::count_t'(MAX_REPORT);
	assign cnt_nxt = cnt_q + elwt_pkg::count_t'(1);
	assign cmd_rng = (32'(cmd.fd) < DESCRIPTOR_COUNT);

	// Evaluation of the slot at the end of the walk pipeline. Descriptors
	// beyond the readiness store always read as not ready.
	always_comb begin
		match_s2 = slot_s2.used && (slot_s2.desc == fd_q);
		rdy_eff  = rng_s2 ? rdy_rd : '0;
		wanted   = rdy_eff & (slot_s2.interest | elwt_pkg::BIT_ERR | elwt_pkg::BIT_HUP);
		rep      = slot_s2.edge_trig ? (wanted & ~slot_s2.seen) : wanted;
		ev_hit   = hit && (act_q == elwt_pkg::ACT_SCAN) && slot_s2.used && (rep != '0);
		stop     = 1'b0;
		if (hit) begin
			unique case (act_q)
				elwt_pkg::ACT_ADD,
				elwt_pkg::ACT_MODIFY,
				elwt_pkg::ACT_REMOVE: stop = match_s2;
				elwt_pkg::ACT_PROBE:  stop = slot_s2.used && (wanted != '0);
				elwt_pkg::ACT_SCAN:   stop = ev_hit && (cnt_nxt == lim_q);
				default:              stop = 1'b0;
			endcase
		end
	end

	// Slot memory write port: clearing pass, walk updates, then the add commit.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_s2;
		slot_wdata = slot_s2;
		priority if (state_q == ST_CLEAR) begin
			slot_we    = (32'(clr_q) < WATCH_SLOTS);
			slot_waddr = SA'(clr_q);
			slot_wdata = '0;
		end else if (hit && match_s2 && (act_q == elwt_pkg::ACT_MODIFY)) begin
			slot_we              = 1'b1;
			slot_wdata.interest  = mask_q;
			slot_wdata.edge_trig = edge_q;
			slot_wdata.tag       = tag_q;
			slot_wdata.seen      = '0;
		end else if (hit && match_s2 && (act_q == elwt_pkg::ACT_REMOVE)) begin
			slot_we         = 1'b1;
			slot_wdata.used = 1'b0;
		end else if (hit && slot_s2.used && (act_q == elwt_pkg::ACT_SCAN)) begin
			// Every visited watch remembers what it saw, reported or not.
			slot_we         = 1'b1;
			slot_wdata.seen = wanted;
		end else if ((state_q == ST_FIN) && adv && (act_q == elwt_pkg::ACT_ADD)
			&& !dup_q && free_vld_q) begin
			slot_we    = 1'b1;
			slot_waddr = free_idx_q;
			slot_wdata = '{used: 1'b1, desc: fd_q, interest: mask_q, edge_trig: edge_q,
				seen: '0, tag: tag_q};
		end else begin
			slot_we = 1'b0;
		end
	end

	// Readiness memory write port: clearing pass or a set readiness command.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			rdy_we    = (32'(clr_q) < DESCRIPTOR_COUNT);
			rdy_waddr = DA'(clr_q);
			rdy_wdata = '0;
		end else begin
			rdy_we    = accept && (cmd.action == elwt_pkg::ACT_SETRDY) && cmd_rng;
			rdy_waddr = DA'(cmd.fd);
			rdy_wdata = cmd.ready_bits;
		end
	end

	// Final result of a command, loaded when the sequencer leaves ST_FIN.
	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		unique case (act_q)
			elwt_pkg::ACT_ADD: begin
				fin_res.status = dup_q ? elwt_pkg::ST_ALREADY
					: (free_vld_q ? elwt_pkg::ST_OK : elwt_pkg::ST_FULL);
			end
			elwt_pkg::ACT_MODIFY,
			elwt_pkg::ACT_REMOVE: begin
				fin_res.status = found_q ? elwt_pkg::ST_OK : elwt_pkg::ST_NOT_WATCHED;
			end
			elwt_pkg::ACT_SCAN: begin
				if (pend_vld_q) begin
					fin_res.is_event    = 1'b1;
					fin_res.report_bits = pend_bits_q;
					fin_res.user_tag    = pend_tag_q;
					fin_res.event_count = pend_cnt_q;
				end
			end
			elwt_pkg::ACT_PROBE: fin_res.any_ready = any_q;
			default:             fin_res.status = elwt_pkg::ST_OK;
		endcase
	end

	// A new scan event pushes the previous pending one out as a non-final result.
	always_comb begin
		out_load = 1'b0;
		out_data = fin_res;
		if ((state_q == ST_FIN) && adv) begin
			out_load = 1'b1;
		end else if (ev_hit && pend_vld_q) begin
			out_load             = 1'b1;
			out_data             = '0;
			out_data.is_event    = 1'b1;
			out_data.report_bits = pend_bits_q;
			out_data.user_tag    = pend_tag_q;
			out_data.event_count = pend_cnt_q;
		end
	end

	// Sequencer and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			issue_q      <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			max_events_q <= elwt_pkg::MAX_EVENTS_RST;
			cnt_q        <= '0;
			lim_q        <= '0;
			dup_q        <= 1'b0;
			free_vld_q   <= 1'b0;
			found_q      <= 1'b0;
			any_q        <= 1'b0;
			pend_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_events_q <= cfg_data;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						issue_q    <= '0;
						cnt_q      <= '0;
						lim_q      <= limit;
						dup_q      <= 1'b0;
						free_vld_q <= 1'b0;
						found_q    <= 1'b0;
						any_q      <= 1'b0;
						pend_vld_q <= 1'b0;
						if ((cmd.action == elwt_pkg::ACT_SCAN) && (limit == '0)) begin
							state_q <= ST_FIN;
						end else if ((cmd.action == elwt_pkg::ACT_ADD)
							|| (cmd.action == elwt_pkg::ACT_MODIFY)
							|| (cmd.action == elwt_pkg::ACT_REMOVE)
							|| (cmd.action == elwt_pkg::ACT_SCAN)
							|| (cmd.action == elwt_pkg::ACT_PROBE)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WALK: begin
					if (hit) begin
						if (match_s2 && (act_q == elwt_pkg::ACT_ADD)) begin
							dup_q <= 1'b1;
						end
						if (!slot_s2.used && !free_vld_q) begin
							free_vld_q <= 1'b1;
						end
						if (match_s2) begin
							found_q <= 1'b1;
						end
						if (slot_s2.used && (wanted != '0)) begin
							any_q <= 1'b1;
						end
					end
					if (ev_hit) begin
						pend_vld_q <= 1'b1;
						cnt_q      <= cnt_nxt;
					end
					if (stop || walk_end) begin
						state_q <= ST_FIN;
						vld_s1  <= 1'b0;
						vld_s2  <= 1'b0;
					end else if (walk_go) begin
						vld_s1 <= !issue_done;
						vld_s2 <= vld_s1;
						if (!issue_done) begin
							issue_q <= issue_q + IW'(1);
						end
					end
				end
				ST_FIN: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= cmd.action;
			fd_q   <= cmd.fd;
			mask_q <= cmd.event_mask;
			edge_q <= cmd.edge_mode;
			tag_q  <= cmd.cookie;
		end
		if (walk_go) begin
			idx_s1  <= issue_q[SA-1:0];
			idx_s2  <= idx_s1;
			slot_s2 <= slot_rd;
			rng_s2  <= (32'(slot_rd.desc) < DESCRIPTOR_COUNT);
		end
		if (hit && !slot_s2.used && !free_vld_q) begin
			free_idx_q <= idx_s2;
		end
		if (ev_hit) begin
			pend_bits_q <= rep;
			pend_tag_q  <= slot_s2.tag;
			pend_cnt_q  <= cnt_nxt;
		end
		if (out_load) begin
			res_q <= out_data;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = res_q.status;
	assign rsp.is_event    = res_q.is_event;
	assign rsp.report_bits = res_q.report_bits;
	assign rsp.user_tag    = res_q.user_tag;
	assign rsp.event_count = res_q.event_count;
	assign rsp.any_ready   = res_q.any_ready;
	assign rsp.last        = res_q.last;

	// A result is never written over one that the sink has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || rsp.ready))
		else $error("result register overwritten while full");

	// The two walk stages always hold consecutive slots.
	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2) |-> (idx_s1 == idx_s2 + SA'(1)))
		else $error("walk stages out of order");

	// A scan stops walking as soon as its event limit is reached.
	a_scan_limit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && (act_q == elwt_pkg::ACT_SCAN)) |-> (cnt_q < lim_q))
		else $error("scan walked past its event limit");

	// Only a scan holds a pending event, and the pipeline is empty outside a walk.
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vld_q || vld_s1 || vld_s2) |->
		((act_q == elwt_pkg::ACT_SCAN) || (state_q == ST_WALK)))
		else $error("walk state outside of a walk");

endmodule

// ===== sv/elwt_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered,
// enable-held read data. No package dependencies.
module elwt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low so a stalled walk keeps its word.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for edge_level_event_watch_table: sends watch commands on
// the cmd channel and checks every rsp transfer against its own model of the table.
// Depends on elwt_pkg, the elwt_cmd_if / elwt_rsp_if interfaces and the block's RTL.
module testbench;

	localparam int SLOTS       = 256;
	localparam int FD_SPAN     = 256;
	localparam int REPORT_CAP  = 64;
	localparam int WALK_CYCLES = SLOTS + 8;

	// The action field is three bits wide, but only six codes are defined.
	// The two spare codes must give one final ST_OK result with no event and change nothing.
	localparam elwt_pkg::action_t ACT_SPARE_6 = 3'd6;
	localparam elwt_pkg::action_t ACT_SPARE_7 = 3'd7;

	// One command as the model of the table sees it.
	typedef struct {
		elwt_pkg::action_t action;
		elwt_pkg::fd_t     fd;
		elwt_pkg::bits_t   mask;
		logic              edge_on;
		elwt_pkg::tag_t    tag;
		elwt_pkg::bits_t   rdy;
	} watch_cmd_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	elwt_pkg::count_t cfg_data;

	elwt_cmd_if cmd_ch ();
	elwt_rsp_if rsp_ch ();

	edge_level_event_watch_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	// Our own copy of the watch table, the readiness store and the scan limit.
	logic             watch_used     [SLOTS];
	elwt_pkg::fd_t    watch_fd       [SLOTS];
	elwt_pkg::bits_t  watch_interest [SLOTS];
	logic             watch_edge     [SLOTS];
	elwt_pkg::tag_t   watch_tag      [SLOTS];
	elwt_pkg::bits_t  watch_seen     [SLOTS];
	elwt_pkg::bits_t  fd_readiness   [FD_SPAN];
	elwt_pkg::count_t scan_cap;

	// Results we have worked out but not yet seen on the rsp channel, oldest first.
	elwt_pkg::res_t awaited_rsp[$];
	int             bad_results;

	// Idling control shared by the command sender and the result receiver.
	// idle_pct is the chance, per opportunity, of a burst of idle cycles.
	// hold_off_cycles asks the receiver for one long stall, which it counts itself.
	bit no_idle;
	int idle_pct;
	int hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit on the run: several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int watch_slot_of(elwt_pkg::fd_t d);
		for (int i = 0; i < SLOTS; i++) begin
			if (watch_used[i] && watch_fd[i] == d) return i;
		end
		return -1;
	endfunction

	// Readiness of a slot's descriptor filtered by what the slot cares about.
	// Error and hang-up always get through, whatever the interest mask says.
	function automatic elwt_pkg::bits_t wanted_bits(int s);
		return fd_readiness[watch_fd[s]]
			& (watch_interest[s] | elwt_pkg::BIT_ERR | elwt_pkg::BIT_HUP);
	endfunction

	// A single, final result that carries no event.
	function automatic elwt_pkg::res_t plain_rsp(elwt_pkg::status_t st, logic any);
		elwt_pkg::res_t r;
		r = '0;
		r.status = st;
		r.any_ready = any;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic string rsp_text(elwt_pkg::res_t r);
		return $sformatf("status=%0d event=%0b bits=%02h tag=%016h count=%0d any=%0b last=%0b",
			r.status, r.is_event, r.report_bits, r.user_tag, r.event_count, r.any_ready,
			r.last);
	endfunction

	task automatic note_failure(input string what);
		bad_results++;
		if (bad_results <= 10) $display("mismatch: %s", what);
	endtask

	// Applies one accepted command to the table copy and queues the results it
	// must produce, in the order the block has to deliver them.
	task automatic apply_watch_command(input watch_cmd_t c);
		int              s;
		int              f;
		int              limit;
		int              hits;
		elwt_pkg::bits_t now_bits;
		elwt_pkg::bits_t fresh;
		logic            any;
		elwt_pkg::res_t  ev;
		s = watch_slot_of(c.fd);
		case (c.action)
			elwt_pkg::ACT_ADD: begin
				if (s >= 0) begin
					awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_ALREADY, 1'b0));
				end else begin
					f = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (!watch_used[i]) begin
							f = i;
							break;
						end
					end
					if (f < 0) begin
						awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_FULL, 1'b0));
					end else begin
						watch_used[f] = 1'b1;
						watch_fd[f] = c.fd;
						watch_interest[f] = c.mask;
						watch_edge[f] = c.edge_on;
						watch_tag[f] = c.tag;
						watch_seen[f] = '0;
						awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, 1'b0));
					end
				end
			end
			elwt_pkg::ACT_MODIFY, elwt_pkg::ACT_REMOVE: begin
				if (s < 0) begin
					awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_NOT_WATCHED, 1'b0));
				end else begin
					if (c.action == elwt_pkg::ACT_MODIFY) begin
						watch_interest[s] = c.mask;
						watch_edge[s] = c.edge_on;
						watch_tag[s] = c.tag;
						watch_seen[s] = '0;
					end else begin
						watch_used[s] = 1'b0;
					end
					awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, 1'b0));
				end
			end
			elwt_pkg::ACT_SETRDY: begin
				fd_readiness[c.fd] = c.rdy;
				awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, 1'b0));
			end
			elwt_pkg::ACT_SCAN: begin
				// The walk stops as soon as the limit is reached; slots past that
				// point are not visited and keep their last seen state.
				limit = (scan_cap > REPORT_CAP) ? REPORT_CAP : int'(scan_cap);
				hits = 0;
				for (int i = 0; i < SLOTS && hits < limit; i++) begin
					if (watch_used[i]) begin
						now_bits = wanted_bits(i);
						fresh = watch_edge[i] ? (now_bits & ~watch_seen[i]) : now_bits;
						watch_seen[i] = now_bits;
						if (fresh != '0) begin
							hits++;
							ev = '0;
							ev.is_event = 1'b1;
							ev.report_bits = fresh;
							ev.user_tag = watch_tag[i];
							ev.event_count = elwt_pkg::count_t'(hits);
							awaited_rsp.push_back(ev);
						end
					end
				end
				if (hits == 0) begin
					awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, 1'b0));
				end else begin
					ev = awaited_rsp.pop_back();
					ev.last = 1'b1;
					awaited_rsp.push_back(ev);
				end
			end
			elwt_pkg::ACT_PROBE: begin
				any = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (watch_used[i] && wanted_bits(i) != '0) any = 1'b1;
				end
				awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, any));
			end
			default: begin
				awaited_rsp.push_back(plain_rsp(elwt_pkg::ST_OK, 1'b0));
			end
		endcase
	endtask

	// Offers one command and returns at the edge where it is accepted. Valid is
	// left high, so the caller must either offer the next command or drop valid
	// in that same time step; a gap drops it before the idle cycles.
	task automatic issue(input elwt_pkg::action_t act, input elwt_pkg::fd_t d,
		input elwt_pkg::bits_t mask, input logic edge_on, input elwt_pkg::tag_t tag,
		input elwt_pkg::bits_t rdy);
		watch_cmd_t c;
		int         gap;
		c.action = act;
		c.fd = d;
		c.mask = mask;
		c.edge_on = edge_on;
		c.tag = tag;
		c.rdy = rdy;
		if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 7);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.fd <= d;
		cmd_ch.event_mask <= mask;
		cmd_ch.edge_mode <= edge_on;
		cmd_ch.cookie <= tag;
		cmd_ch.ready_bits <= rdy;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		apply_watch_command(c);
	endtask

	// Stops offering and waits until every queued result has been transferred.
	// Every command yields at least one result, so the block is idle after that.
	task automatic wait_for_quiet_table();
		cmd_ch.valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes max_events; meant to be called only while the block is idle, which the task does not check.
	task automatic write_scan_cap(input elwt_pkg::count_t v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		scan_cap = v;
	endtask

	// Result receiver. Ready drops in short random bursts, or for one long
	// counted stretch when a test asks for it through hold_off_cycles.
	initial begin : rsp_sink
		int span;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
				span = $urandom_range(1, 7);
				rsp_ch.ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Result checker: every transfer on rsp must match the oldest expectation.
	always @(posedge clk) begin : rsp_check
		elwt_pkg::res_t got;
		elwt_pkg::res_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.status = rsp_ch.status;
			got.is_event = rsp_ch.is_event;
			got.report_bits = rsp_ch.report_bits;
			got.user_tag = rsp_ch.user_tag;
			got.event_count = rsp_ch.event_count;
			got.any_ready = rsp_ch.any_ready;
			got.last = rsp_ch.last;
			if (awaited_rsp.size() == 0) begin
				note_failure({"result with nothing expected: ", rsp_text(got)});
			end else begin
				want = awaited_rsp.pop_front();
				if (got !== want) begin
					note_failure({"expected ", rsp_text(want), " got ", rsp_text(got)});
				end
			end
		end
	end

	// Hand-picked commands: descriptor and tag extremes, every action, duplicate
	// add, modify and remove of an unwatched descriptor, level against edge
	// reporting, modify clearing the seen state, and both spare action codes.
	task automatic test_directed_cases();
		issue(elwt_pkg::ACT_ADD, 8'd0, 5'h1F, 1'b0, '1, 5'h00);
		issue(elwt_pkg::ACT_ADD, 8'd255, 5'h00, 1'b1, '0, 5'h1F);
		issue(elwt_pkg::ACT_ADD, 8'd0, 5'h03, 1'b1, 64'h1234_5678_9ABC_DEF0, 5'h00);
		issue(elwt_pkg::ACT_MODIFY, 8'd7, 5'h1F, 1'b1, '1, 5'h00);
		issue(elwt_pkg::ACT_REMOVE, 8'd7, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_PROBE, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SETRDY, 8'd0, 5'h00, 1'b0, '0, 5'h1F);
		issue(elwt_pkg::ACT_SETRDY, 8'd255, 5'h1F, 1'b1, '1, 5'h1F);
		issue(elwt_pkg::ACT_PROBE, 8'd255, 5'h1F, 1'b1, '1, 5'h1F);
		// The level slot reports twice; the edge slot only on its first visit.
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd255, 5'h1F, 1'b1, '1, 5'h1F);
		issue(elwt_pkg::ACT_MODIFY, 8'd255, 5'h05, 1'b1, 64'hA5A5_0F0F_5A5A_F0F0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SETRDY, 8'd255, 5'h00, 1'b0, '0, 5'h07);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(ACT_SPARE_6, 8'd255, 5'h1F, 1'b1, '1, 5'h1F);
		issue(ACT_SPARE_7, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_MODIFY, 8'd0, 5'h00, 1'b1, 64'h8000_0000_0000_0001, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_REMOVE, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_REMOVE, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_ADD, 8'd128, 5'h0A, 1'b0, 64'h0000_0000_FFFF_FFFF, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
	endtask

	// Scan limit settings: zero visits nothing, one stops after the first event,
	// and a value above the cap behaves as the cap.
	task automatic test_scan_limits();
		wait_for_quiet_table();
		write_scan_cap(7'd0);
		issue(elwt_pkg::ACT_ADD, 8'd40, 5'h1F, 1'b1, 64'hDEAD_BEEF_0000_0040, 5'h00);
		issue(elwt_pkg::ACT_SETRDY, 8'd40, 5'h00, 1'b0, '0, 5'h11);
		issue(elwt_pkg::ACT_SETRDY, 8'd128, 5'h00, 1'b0, '0, 5'h0A);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		wait_for_quiet_table();
		write_scan_cap(7'd1);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		wait_for_quiet_table();
		write_scan_cap(7'd127);
		issue(elwt_pkg::ACT_SETRDY, 8'd40, 5'h00, 1'b0, '0, 5'h1F);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_PROBE, 8'd0, 5'h00, 1'b0, '0, 5'h00);
	endtask

	// Fills more slots than one scan may report, then holds the receiver off for
	// a long stretch while scans keep coming, so the block backs up onto cmd.
	// The slots are edge triggered, so later scans stay short unless poked.
	task automatic test_stalled_results();
		wait_for_quiet_table();
		write_scan_cap(elwt_pkg::MAX_EVENTS_RST);
		for (int k = 0; k < REPORT_CAP + 2; k++) begin
			issue(elwt_pkg::ACT_ADD, elwt_pkg::fd_t'(100 + k),
				elwt_pkg::bits_t'($urandom_range(0, 31)), 1'b1, {$urandom, $urandom}, 5'h00);
			issue(elwt_pkg::ACT_SETRDY, elwt_pkg::fd_t'(100 + k), 5'h00, 1'b0, '0,
				elwt_pkg::bits_t'($urandom_range(1, 31)));
		end
		hold_off_cycles = 600;
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_PROBE, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		issue(elwt_pkg::ACT_SCAN, 8'd0, 5'h00, 1'b0, '0, 5'h00);
		// The sender now pauses until everything queued has come out.
		wait_for_quiet_table();
	endtask

	// Random traffic with a given scan limit and idling rate. Descriptors come
	// mostly from a small pool so that adds, modifies and removes hit each other
	// and scans find plenty of ready slots; the rest span the whole field.
	task automatic run_random_phase(input int items, input elwt_pkg::count_t cap,
		input int pct);
		int                pick;
		elwt_pkg::action_t act;
		elwt_pkg::fd_t     d;
		wait_for_quiet_table();
		write_scan_cap(cap);
		idle_pct = pct;
		no_idle = (pct == 0);
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 26) act = elwt_pkg::ACT_ADD;
			else if (pick < 37) act = elwt_pkg::ACT_MODIFY;
			else if (pick < 47) act = elwt_pkg::ACT_REMOVE;
			else if (pick < 72) act = elwt_pkg::ACT_SETRDY;
			else if (pick < 88) act = elwt_pkg::ACT_SCAN;
			else if (pick < 96) act = elwt_pkg::ACT_PROBE;
			else act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
			if ($urandom_range(0, 4) == 0) d = elwt_pkg::fd_t'($urandom_range(0, 255));
			else d = elwt_pkg::fd_t'($urandom_range(0, 31));
			issue(act, d, elwt_pkg::bits_t'($urandom_range(0, 31)),
				logic'($urandom_range(0, 1)), {$urandom, $urandom},
				elwt_pkg::bits_t'($urandom_range(0, 31)));
		end
	endtask

	initial begin
		// Every block input gets a known value before the first edge.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = elwt_pkg::ACT_ADD;
		cmd_ch.fd = '0;
		cmd_ch.event_mask = '0;
		cmd_ch.edge_mode = 1'b0;
		cmd_ch.cookie = '0;
		cmd_ch.ready_bits = '0;
		bad_results = 0;
		no_idle = 1'b0;
		idle_pct = 25;
		hold_off_cycles = 0;
		scan_cap = elwt_pkg::MAX_EVENTS_RST;
		for (int i = 0; i < SLOTS; i++) begin
			watch_used[i] = 1'b0;
			watch_fd[i] = '0;
			watch_interest[i] = '0;
			watch_edge[i] = 1'b0;
			watch_tag[i] = '0;
			watch_seen[i] = '0;
		end
		for (int i = 0; i < FD_SPAN; i++) fd_readiness[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its memories after reset with cmd.ready low; the first
		// command simply waits for that to finish.
		write_scan_cap(elwt_pkg::MAX_EVENTS_RST);

		test_directed_cases();
		test_scan_limits();
		test_stalled_results();
		run_random_phase(45, 7'd64, 30);
		run_random_phase(45, 7'd2, 10);
		run_random_phase(45, 7'd9, 50);
		run_random_phase(45, 7'd127, 0);

		wait_for_quiet_table();
		repeat (WALK_CYCLES) @(posedge clk);
		if (bad_results == 0 && awaited_rsp.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/elwt_pkg.sv
sv/elwt_ifs.sv
sv/elwt_ram.sv
sv/edge_level_event_watch_table.sv
tb/testbench.sv
